// File: design/dlpd_pkg.sv
// ============================================================================
// dlpd_pkg: shared types and constants of the line program decoder
// Opcode codes, header config indices and the divider request/response structs.
// ============================================================================
package dlpd_pkg;

    localparam logic [7:0] OP_EXTENDED   = 8'h00;
    localparam logic [7:0] OP_COPY       = 8'h01;
    localparam logic [7:0] OP_ADV_PC     = 8'h02;
    localparam logic [7:0] OP_ADV_LINE   = 8'h03;
    localparam logic [7:0] OP_SET_FILE   = 8'h04;
    localparam logic [7:0] OP_NEG_STMT   = 8'h06;
    localparam logic [7:0] OP_CONST_ADD  = 8'h08;

    localparam logic [7:0] EXT_END_SEQ   = 8'h01;
    localparam logic [7:0] EXT_SET_ADDR  = 8'h02;
    localparam logic [7:0] EXT_SET_DISC  = 8'h04;

    localparam logic [7:0] CONST_ADD_OP  = 8'd255;

    localparam logic [2:0] CFG_MIN_INST  = 3'd0;
    localparam logic [2:0] CFG_LINE_BASE = 3'd1;
    localparam logic [2:0] CFG_LINE_RNG  = 3'd2;
    localparam logic [2:0] CFG_OP_BASE   = 3'd3;
    localparam logic [2:0] CFG_FILE_BASE = 3'd4;

    // divide request from sequencer to the shared divider
    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [7:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quot;
        logic [7:0] rem;
    } t_div_rsp;

endpackage

// File: design/dlpd_div.sv
// ============================================================================
// dlpd_div: shared 8-bit restoring divider
// One quotient bit per cycle; zero divisor gives quotient 0, remainder dividend.
// ============================================================================
module dlpd_div
    import dlpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [7:0] r_quot, n_quot;
    logic [8:0] r_rem, n_rem;
    logic [7:0] r_div;
    logic [7:0] r_dvd;
    logic [3:0] r_cnt, n_cnt;
    logic       r_busy, n_busy;
    logic       r_done, n_done;
    logic [8:0] w_trial;

    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem[7:0], r_quot[7]};
        if (i_req.start) begin
            n_quot = i_req.dividend;
            n_rem  = 9'd0;
            n_cnt  = 4'd8;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift one bit in, subtract if it fits
            if (w_trial >= {1'b0, r_div}) begin
                n_rem  = w_trial - {1'b0, r_div};
                n_quot = {r_quot[6:0], 1'b1};
            end else begin
                n_rem  = w_trial;
                n_quot = {r_quot[6:0], 1'b0};
            end
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_req.start) begin
            r_div <= i_req.divisor;
            r_dvd <= i_req.dividend;
        end
    end

    // a zero divisor leaves every trial fitting: quotient 0xFF; fix up here
    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_div == 8'd0) ? 8'd0 : r_quot;
    assign o_rsp.rem  = (r_div == 8'd0) ? r_dvd : r_rem[7:0];

    // no restart while a division runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("divider restarted while busy");
    // done only after the last step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    // step count stays live while busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != 4'd0)) else $error("divider busy with zero count");

endmodule

// File: design/dwarf_line_program_decoder.sv
// ============================================================================
// dwarf_line_program_decoder: byte-serial line-number program decoder
// Decodes opcodes and operands into address/file/line and emits rows.
// ============================================================================
// Usage:
//   Input channel (i_valid/o_ready) carries one program byte per request
//   with i_unit_start to clear state before that byte. Output channel
//   (o_valid/i_ready) carries at most one result per byte: a row (kind 0)
//   or an unsupported opcode error (kind 1).
//   Configuration (i_cfg_valid/o_cfg_ready, index, data) is to be written by the user
//   only while idle; the block itself does not enforce this. The header fields come from software.
//   Timing: a byte passes the accept and execute states; a special opcode or
//   const_add_pc then runs the shared 8-bit divider, one quotient bit per
//   cycle, before the multiply and add. The divider sets the worst-case rate.
//   The address multiply by min_inst_length takes its own registered step.
//   The result sits in an output register; the next byte is accepted only
//   when that register is free, so a stalled receiver stalls input.
//   Reset clears the decoder to expect an opcode, address 0, file 1,
//   line 1, and restores the header defaults.
module dwarf_line_program_decoder
    import dlpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_prog_byte,
    input  logic        i_unit_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [63:0] o_row_address,
    output logic [15:0] o_row_file,
    output logic signed [31:0] o_row_line,
    output logic        o_end_of_seq,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_DIV, S_MUL, S_ADD
    } t_state;

    typedef enum logic [2:0] {
        PH_OPCODE, PH_ULEB, PH_SLEB, PH_EXT_LEN, PH_EXT_OP, PH_ADDR8
    } t_phase;

    t_state      r_state;
    t_phase      r_phase;
    logic [7:0]  r_pend, r_byte;
    logic [63:0] r_acc;
    logic [6:0]  r_shift;
    logic [3:0]  r_left;
    logic [63:0] r_addr;
    logic [15:0] r_file;
    logic [31:0] r_line;
    logic        r_spec;      // special opcode: emit row after add
    logic [63:0] r_prod;
    logic [7:0]  r_min, r_lbase, r_lrng, r_obase;
    logic [15:0] r_fbase;
    logic        r_ov;
    logic        r_kind, r_eos;
    logic [63:0] r_oaddr;
    logic [15:0] r_ofile;
    logic [31:0] r_oline;

    t_div_req w_req;
    t_div_rsp w_rsp;

    dlpd_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign o_ready     = (r_state == S_IDLE) && !r_ov;
    assign o_cfg_ready = 1'b1;
    assign o_valid       = r_ov;
    assign o_kind        = r_kind;
    assign o_row_address = r_oaddr;
    assign o_row_file    = r_ofile;
    assign o_row_line    = r_oline;
    assign o_end_of_seq  = r_eos;

    // divider request: special opcode splits byte - r_obase,
    // const_add_pc splits 255 - r_obase
    always_comb begin
        w_req.start    = 1'b0;
        w_req.divisor  = r_lrng;
        w_req.dividend = r_byte - r_obase;
        if (r_state == S_EXEC && r_phase == PH_OPCODE) begin
            if (r_byte != OP_EXTENDED && r_byte >= r_obase) begin
                w_req.start = 1'b1;
            end else if (r_byte == OP_CONST_ADD) begin
                w_req.start    = 1'b1;
                w_req.dividend = CONST_ADD_OP - r_obase;
            end
        end
    end

    // LEB payload of current byte placed at r_shift (bits >= 64 dropped)
    logic [63:0] w_leb;
    logic [6:0]  w_shn;
    logic [63:0] w_sacc;
    logic [15:0] w_file_sum;
    always_comb begin
        w_leb  = (r_shift < 7'd64) ? (r_acc | ({57'd0, r_byte[6:0]} << r_shift[5:0]))
                                   : r_acc;
        w_shn  = (r_shift < 7'd64) ? r_shift + 7'd7 : r_shift;
        w_sacc = w_leb;
        if (w_shn < 7'd64 && r_byte[6]) begin
            w_sacc = w_leb | ({64{1'b1}} << w_shn[5:0]);
        end
    end

    logic [16:0] w_fs;
    always_comb begin
        w_fs = {1'b0, r_file} + {1'b0, r_fbase} - 17'd1;
        if (r_file == 16'd0) begin
            w_file_sum = 16'd0;
        end else if (w_fs[16]) begin
            w_file_sum = 16'hFFFF;
        end else begin
            w_file_sum = w_fs[15:0];
        end
    end

    // sequencer: decodes each byte; a row is emitted only when the address is nonzero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_OPCODE;
            r_pend  <= 8'd0;
            r_acc   <= 64'd0;
            r_shift <= 7'd0;
            r_left  <= 4'd0;
            r_addr  <= 64'd0;
            r_file  <= 16'd1;
            r_line  <= 32'd1;
            r_ov    <= 1'b0;
            r_spec  <= 1'b0;
            r_min   <= 8'd1;
            r_lbase <= 8'hFB;
            r_lrng  <= 8'd14;
            r_obase <= 8'd13;
            r_fbase <= 16'd0;
        end else begin
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_INST:  r_min   <= i_cfg_data[7:0];
                    CFG_LINE_BASE: r_lbase <= i_cfg_data[7:0];
                    CFG_LINE_RNG:  r_lrng  <= i_cfg_data[7:0];
                    CFG_OP_BASE:   r_obase <= i_cfg_data[7:0];
                    CFG_FILE_BASE: r_fbase <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_byte  <= i_prog_byte;
                        r_state <= S_EXEC;
                        if (i_unit_start) begin
                            r_phase <= PH_OPCODE;
                            r_pend  <= 8'd0;
                            r_acc   <= 64'd0;
                            r_shift <= 7'd0;
                            r_left  <= 4'd0;
                            r_addr  <= 64'd0;
                            r_file  <= 16'd1;
                            r_line  <= 32'd1;
                        end
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    unique case (r_phase)
                        PH_ULEB: begin
                            r_acc   <= w_leb;
                            r_shift <= w_shn;
                            if (!r_byte[7]) begin
                                r_phase <= PH_OPCODE;
                                if (r_pend == OP_ADV_PC) begin
                                    r_acc   <= w_leb;
                                    r_spec  <= 1'b0;
                                    r_state <= S_MUL;
                                end else if (r_pend == OP_SET_FILE) begin
                                    r_file <= (w_leb > 64'd65535) ? 16'hFFFF
                                                                  : w_leb[15:0];
                                end
                            end
                        end
                        PH_SLEB: begin
                            r_acc   <= w_leb;
                            r_shift <= w_shn;
                            if (!r_byte[7]) begin
                                r_line  <= r_line + w_sacc[31:0];
                                r_phase <= PH_OPCODE;
                            end
                        end
                        PH_EXT_LEN: begin
                            if (!r_byte[7]) begin
                                r_phase <= PH_EXT_OP;
                            end
                        end
                        PH_EXT_OP: begin
                            r_phase <= PH_OPCODE;
                            if (r_byte == EXT_END_SEQ) begin
                                if (r_addr != 64'd0) begin
                                    r_ov    <= 1'b1;
                                    r_kind  <= 1'b0;
                                    r_oaddr <= r_addr;
                                    r_ofile <= w_file_sum;
                                    r_oline <= r_line;
                                    r_eos   <= 1'b1;
                                end
                                r_addr <= 64'd0;
                                r_file <= 16'd1;
                                r_line <= 32'd1;
                            end else if (r_byte == EXT_SET_ADDR) begin
                                r_phase <= PH_ADDR8;
                                r_acc   <= 64'd0;
                                r_shift <= 7'd0;
                                r_left  <= 4'd8;
                            end else if (r_byte == EXT_SET_DISC) begin
                                r_phase <= PH_ULEB;
                                r_pend  <= 8'd0;
                                r_acc   <= 64'd0;
                                r_shift <= 7'd0;
                            end else begin
                                r_ov    <= 1'b1;
                                r_kind  <= 1'b1;
                                r_oaddr <= 64'd0;
                                r_ofile <= 16'd0;
                                r_oline <= 32'd0;
                                r_eos   <= 1'b0;
                            end
                        end
                        PH_ADDR8: begin
                            if (r_shift < 7'd64) begin
                                r_acc <= r_acc | ({56'd0, r_byte} << r_shift[5:0]);
                            end
                            r_shift <= r_shift + 7'd8;
                            if (r_left <= 4'd1) begin
                                r_left  <= 4'd0;
                                r_phase <= PH_OPCODE;
                                r_addr  <= (r_shift < 7'd64)
                                    ? (r_acc | ({56'd0, r_byte} << r_shift[5:0])) : r_acc;
                            end else begin
                                r_left <= r_left - 4'd1;
                            end
                        end
                        default: begin
                            r_phase <= PH_OPCODE;
                            if (r_byte == OP_EXTENDED) begin
                                r_phase <= PH_EXT_LEN;
                            end else if (r_byte >= r_obase) begin
                                r_spec  <= 1'b1;
                                r_state <= S_DIV;
                            end else if (r_byte == OP_COPY) begin
                                if (r_addr != 64'd0) begin
                                    r_ov    <= 1'b1;
                                    r_kind  <= 1'b0;
                                    r_oaddr <= r_addr;
                                    r_ofile <= w_file_sum;
                                    r_oline <= r_line;
                                    r_eos   <= 1'b0;
                                end
                            end else if (r_byte == OP_ADV_PC || r_byte == OP_SET_FILE) begin
                                r_phase <= PH_ULEB;
                                r_pend  <= r_byte;
                                r_acc   <= 64'd0;
                                r_shift <= 7'd0;
                            end else if (r_byte == OP_ADV_LINE) begin
                                r_phase <= PH_SLEB;
                                r_pend  <= r_byte;
                                r_acc   <= 64'd0;
                                r_shift <= 7'd0;
                            end else if (r_byte == OP_NEG_STMT) begin
                                r_phase <= PH_OPCODE;
                            end else if (r_byte == OP_CONST_ADD) begin
                                r_spec  <= 1'b0;
                                r_state <= S_DIV;
                            end else begin
                                r_ov    <= 1'b1;
                                r_kind  <= 1'b1;
                                r_oaddr <= 64'd0;
                                r_ofile <= 16'd0;
                                r_oline <= 32'd0;
                                r_eos   <= 1'b0;
                            end
                        end
                    endcase
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        r_acc   <= {56'd0, w_rsp.quot};
                        r_state <= S_MUL;
                        if (r_spec) begin
                            r_line <= r_line + {{24{r_lbase[7]}}, r_lbase}
                                             + {24'd0, w_rsp.rem};
                        end
                    end
                end
                S_MUL: begin
                    // 64x8 multiply, registered before the add
                    r_prod  <= r_acc * {56'd0, r_min};
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_addr  <= r_addr + r_prod;
                    r_state <= S_IDLE;
                    if (r_spec && (r_addr + r_prod) != 64'd0) begin
                        r_ov    <= 1'b1;
                        r_kind  <= 1'b0;
                        r_oaddr <= r_addr + r_prod;
                        r_ofile <= w_file_sum;
                        r_oline <= r_line;
                        r_eos   <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no input accepted while a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !o_ready) else $error("input taken over pending result");
    // divider only finishes while waiting for it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == S_DIV) else $error("stray divider done");
    // error results carry zero payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_kind) |-> (r_oaddr == 64'd0 && !r_eos))
        else $error("error result with payload");

endmodule

// File: bench/dwarf_line_program_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwarf_line_program_decoder_tb: self-checking bench of the line decoder
// Streams directed and random line-program bytes through the decoder,
// predicts every row and error result in a behavioral model of the line
// state machine, and compares each output request against that model.
// ----------------------------------------------------------------------------
module dwarf_line_program_decoder_tb;
    import dlpd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_prog_byte;
    logic        i_unit_start;
    logic        o_valid;
    logic        i_ready;
    logic        o_kind;
    logic [63:0] o_row_address;
    logic [15:0] o_row_file;
    logic signed [31:0] o_row_line;
    logic        o_end_of_seq;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    dwarf_line_program_decoder DUT (.*);

    typedef struct packed {
        logic [7:0] prog_byte;
        logic       unit_start;
    } byte_req_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] address;
        logic [15:0] file;
        logic [31:0] line;
        logic        eos;
    } line_row_t;

    typedef enum logic [2:0] {
        PH_OPCODE, PH_ULEB, PH_SLEB, PH_EXT_LEN, PH_EXT_OP, PH_ADDR8
    } phase_e;

    // Requests waiting for the driver and rows waiting for the monitor
    byte_req_t byte_queue[$];
    line_row_t row_queue[$];
    int        fail_count = 0;
    int        rx_hold = 0;      // long receiver hold-off, in cycles
    bit        tx_pause = 0;

    // Model copy of the header fields and the line state machine
    logic [7:0]  m_min_inst, m_line_base, m_line_range, m_op_base;
    logic [15:0] m_file_base;
    phase_e      m_phase;
    logic [7:0]  m_pend_op;
    logic [63:0] m_accum;
    logic [7:0]  m_shift;
    logic [3:0]  m_bytes_left;
    logic [63:0] m_addr;
    logic [15:0] m_file;
    logic [31:0] m_line;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic void clear_lines();
        m_addr = '0; m_file = 16'd1; m_line = 32'd1;
    endfunction

    function automatic void clear_decode();
        m_phase = PH_OPCODE; m_pend_op = '0; m_accum = '0;
        m_shift = '0; m_bytes_left = '0;
    endfunction

    function automatic void push_row(bit eos);
        line_row_t r;
        logic [16:0] f;
        if (m_addr == 0) return;
        f = {1'b0, m_file};
        if (m_file != 0) begin
            f = m_file + m_file_base - 17'd1;
            if (f > 17'd65535) f = 17'd65535;
        end
        r.kind = 1'b0; r.address = m_addr; r.file = f[15:0];
        r.line = m_line; r.eos = eos;
        row_queue.insert(row_queue.size(), r);
    endfunction

    function automatic void push_error();
        row_queue.insert(row_queue.size(),
            line_row_t'{kind: 1'b1, address: '0, file: '0, line: '0, eos: 1'b0});
    endfunction

    function automatic void take_leb(logic [7:0] b);
        if (m_shift < 64) begin
            m_accum |= 64'(b[6:0]) << m_shift;
            m_shift += 8'd7;
        end
    endfunction

    // Split the adjusted opcode into address and line advances
    function automatic void split_adj(logic [7:0] adj, output logic [7:0] q,
                                      output logic [7:0] r);
        if (m_line_range == 0) begin
            q = '0; r = adj;
        end else begin
            q = adj / m_line_range; r = adj % m_line_range;
        end
    endfunction

    // Advance the model by one accepted program byte
    function automatic void decode_byte(byte_req_t req);
        logic [7:0] b, q, r;
        b = req.prog_byte;
        if (req.unit_start) begin
            clear_decode(); clear_lines();
        end
        case (m_phase)
            PH_ULEB: begin
                take_leb(b);
                if (b[7]) return;
                m_phase = PH_OPCODE;
                if (m_pend_op == OP_ADV_PC)
                    m_addr += m_accum * 64'(m_min_inst);
                else if (m_pend_op == OP_SET_FILE)
                    m_file = (m_accum > 65535) ? 16'hFFFF : m_accum[15:0];
                return;
            end
            PH_SLEB: begin
                take_leb(b);
                if (b[7]) return;
                if (m_shift < 64 && b[6]) m_accum |= ~64'd0 << m_shift;
                m_line += m_accum[31:0];
                m_phase = PH_OPCODE;
                return;
            end
            PH_EXT_LEN: begin
                if (!b[7]) m_phase = PH_EXT_OP;
                return;
            end
            PH_EXT_OP: begin
                m_phase = PH_OPCODE;
                if (b == EXT_END_SEQ) begin
                    push_row(1'b1); clear_lines();
                end else if (b == EXT_SET_ADDR) begin
                    m_phase = PH_ADDR8; m_accum = '0; m_shift = '0; m_bytes_left = 4'd8;
                end else if (b == EXT_SET_DISC) begin
                    m_phase = PH_ULEB; m_pend_op = '0; m_accum = '0; m_shift = '0;
                end else begin
                    push_error();
                end
                return;
            end
            PH_ADDR8: begin
                if (m_shift < 64) m_accum |= 64'(b) << m_shift;
                m_shift += 8'd8;
                if (m_bytes_left > 0) m_bytes_left--;
                if (m_bytes_left == 0) begin
                    m_addr = m_accum; m_phase = PH_OPCODE;
                end
                return;
            end
            default: ;
        endcase
        m_phase = PH_OPCODE;
        if (b == OP_EXTENDED) begin
            m_phase = PH_EXT_LEN;
        end else if (b >= m_op_base) begin
            split_adj(b - m_op_base, q, r);
            m_addr += 64'(q) * 64'(m_min_inst);
            m_line += 32'(signed'(m_line_base)) + 32'(r);
            push_row(1'b0);
        end else begin
            case (b)
                OP_COPY: push_row(1'b0);
                OP_ADV_PC, OP_ADV_LINE, OP_SET_FILE: begin
                    m_phase = (b == OP_ADV_LINE) ? PH_SLEB : PH_ULEB;
                    m_pend_op = b; m_accum = '0; m_shift = '0;
                end
                OP_NEG_STMT: ;
                OP_CONST_ADD: begin
                    split_adj(CONST_ADD_OP - m_op_base, q, r);
                    m_addr += 64'(q) * 64'(m_min_inst);
                end
                default: push_error();
            endcase
        end
    endfunction

    // Driver: offer queued requests with random gaps
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) decode_byte({i_prog_byte, i_unit_start});
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (byte_queue.size() > 0 && !tx_pause) begin
                {i_prog_byte, i_unit_start} <= byte_queue.pop_front();
                i_valid <= 1'b1;
                tx_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                          ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3));
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result request with the oldest prediction
    always @(posedge i_clk) begin
        line_row_t exp_row;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (row_queue.size() == 0) begin
                    $error("unexpected result kind=%0d addr=%h", o_kind, o_row_address);
                    fail_count++;
                end else begin
                    exp_row = row_queue.pop_front();
                    if (o_kind !== exp_row.kind) begin
                        $error("kind: expected %0d, got %0d", exp_row.kind, o_kind);
                        fail_count++;
                    end
                    if (o_row_address !== exp_row.address) begin
                        $error("row_address: expected %h, got %h",
                               exp_row.address, o_row_address);
                        fail_count++;
                    end
                    if (o_row_file !== exp_row.file) begin
                        $error("row_file: expected %0d, got %0d", exp_row.file, o_row_file);
                        fail_count++;
                    end
                    if (o_row_line !== exp_row.line) begin
                        $error("row_line: expected %0d, got %0d",
                               signed'(exp_row.line), o_row_line);
                        fail_count++;
                    end
                    if (o_end_of_seq !== exp_row.eos) begin
                        $error("end_of_seq: expected %0d, got %0d",
                               exp_row.eos, o_end_of_seq);
                        fail_count++;
                    end
                end
            end
            // Hold off for the long stretch, else stall at random
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 9) < 7) ||
                           ($urandom_range(0, 29) == 0 ? 1'b0 : $urandom_range(0, 1));
            end
        end
    end

    task automatic tick(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        while (byte_queue.size() > 0 || i_valid || row_queue.size() > 0) tick(1);
        tick(30);
    endtask

    // Write one header field; both model and block see it
    task automatic write_header(logic [2:0] idx, logic [15:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do tick(1); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_INST:  m_min_inst   = data[7:0];
            CFG_LINE_BASE: m_line_base  = data[7:0];
            CFG_LINE_RNG:  m_line_range = data[7:0];
            CFG_OP_BASE:   m_op_base    = data[7:0];
            CFG_FILE_BASE: m_file_base  = data;
            default: ;
        endcase
    endtask

    task automatic send(logic [7:0] b, logic us = 1'b0);
        byte_queue.insert(byte_queue.size(), byte_req_t'{prog_byte: b, unit_start: us});
    endtask

    task automatic send_leb(logic [63:0] v, bit sgn);
        logic [7:0] b;
        int n;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            b = {i != n - 1, v[6:0]};
            v = sgn ? $signed(v) >>> 7 : v >> 7;
            send(b);
        end
    endtask

    task automatic send_set_addr(logic [63:0] a);
        send(OP_EXTENDED); send(8'd9); send(EXT_SET_ADDR);
        for (int i = 0; i < 8; i++) send(a[8*i +: 8]);
    endtask

    // One well-formed sequence with random content, with some noise
    task automatic send_sequence();
        int n;
        n = $urandom_range(3, 14);
        send_set_addr({$urandom, $urandom} >> $urandom_range(0, 63));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: send(OP_COPY);
                1: begin send(OP_ADV_PC); send_leb({$urandom, $urandom}, 1'b0); end
                2: begin send(OP_ADV_LINE); send_leb({$urandom, $urandom}, 1'b1); end
                3: begin
                    send(OP_SET_FILE); send_leb(64'($urandom_range(0, 70000)), 1'b0);
                end
                4: send($urandom_range(0, 1) ? OP_NEG_STMT : OP_CONST_ADD);
                5: begin
                    send(OP_EXTENDED); send(8'd2); send(EXT_SET_DISC);
                    send_leb(64'($urandom), 1'b0);
                end
                6: send(8'($urandom));
                default: send(8'($urandom_range(13, 255)));
            endcase
        end
        send(OP_EXTENDED); send(8'd1); send(EXT_END_SEQ);
    endtask

    task automatic random_header();
        write_header(CFG_MIN_INST,
                     16'($urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 8)));
        write_header(CFG_LINE_BASE, 16'($urandom_range(0, 255)));
        write_header(CFG_LINE_RNG, 16'($urandom_range(1, 255)));
        write_header(CFG_OP_BASE, 16'($urandom_range(1, 255)));
        write_header(CFG_FILE_BASE, 16'($urandom));
    endtask

    initial begin
        int pause_at;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_prog_byte = '0; i_unit_start = 1'b0; i_ready = 1'b0;
        m_min_inst = 8'd1; m_line_base = 8'hFB; m_line_range = 8'd14;
        m_op_base = 8'd13; m_file_base = '0;
        clear_decode(); clear_lines();
        tick(12);
        i_rst_n <= 1'b1;
        tick(2);

        // Directed: reset header, copy, special, unsupported, line, file and extended opcodes, then the extremes
        send(OP_COPY, 1'b1);                     // zero address: no row
        send_set_addr(64'h8000_0000_0000_0001);
        send(OP_COPY); send(8'd13); send(8'd255);
        send(8'd5); send(8'd7); send(8'd9); send(8'd10); send(8'd12);
        send(OP_ADV_LINE); send(8'hFF); send(8'h7F);   // negative line step
        send(OP_SET_FILE); send(8'hFF); send(8'hFF); send(8'h7F); // saturates
        send(OP_EXTENDED); send(8'd1); send(8'd3);      // unknown extended op
        send(OP_EXTENDED); send(8'd1); send(EXT_END_SEQ);
        drain();
        write_header(CFG_MIN_INST, 16'd255);
        write_header(CFG_LINE_BASE, 16'h0080);
        write_header(CFG_LINE_RNG, 16'd1);
        write_header(CFG_OP_BASE, 16'd1);
        write_header(CFG_FILE_BASE, 16'hFFFF);
        send_set_addr(64'hFFFF_FFFF_FFFF_FFFF);
        send(OP_EXTENDED, 1'b0); send(8'd255); send(8'd1); send(8'd1);
        drain();
        write_header(CFG_LINE_RNG, 16'd255);
        write_header(CFG_OP_BASE, 16'd255);
        write_header(CFG_LINE_BASE, 16'h007F);
        write_header(CFG_FILE_BASE, 16'd0);
        send_set_addr(64'd1); send(8'd255); send(OP_CONST_ADD); send(8'd254);
        send(OP_SET_FILE); send(8'd0); send(OP_COPY);
        // Long LEB128 runs past 64 bits
        send(OP_ADV_PC); for (int i = 0; i < 11; i++) send(8'hFF); send(8'h01);
        send(OP_ADV_LINE); for (int i = 0; i < 10; i++) send(8'h80); send(8'h40);
        send(OP_COPY);
        drain();

        // Fill the block while the receiver holds off
        rx_hold = 300;
        send_set_addr(64'h100);
        repeat (20) send(OP_COPY);
        drain();

        // Random phases, each with its own header setting
        for (int ph = 0; ph < 8; ph++) begin
            random_header();
            for (int k = 0; k < 5; k++) begin
                if ($urandom_range(0, 9) == 0) send(8'($urandom), 1'b1);
                if ($urandom_range(0, 5) == 0) send(8'($urandom));
                send_sequence();
            end
            if (ph == 3) begin
                // Pause the sender halfway until all results are in
                pause_at = byte_queue.size() / 2;
                while (byte_queue.size() > pause_at) tick(1);
                tx_pause = 1;
                while (row_queue.size() > 0 || i_valid) tick(1);
                tick(20);
                tx_pause = 0;
            end
            drain();
        end

        if (fail_count == 0)
            $display("** dwarf_line_program_decoder: PASSED **");
        else
            $display("** dwarf_line_program_decoder: FAILED **");
        $finish;
    end

    initial begin
        #20ms;
        $display("** dwarf_line_program_decoder: FAILED **");
        $finish;
    end

endmodule
